// ===== sv/jsu_pkg.sv =====
// Shared types, character codes and helpers for the JSON string unescape block.
`default_nettype none
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_HEX0   = 3'd2,
        MODE_HEX1   = 3'd3,
        MODE_HEX2   = 3'd4,
        MODE_HEX3   = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_END        = 3'd1,
        KIND_BAD_ESCAPE = 3'd2,
        KIND_BAD_HEX    = 3'd3,
        KIND_SURROGATE  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0]  out_byte;
        t_kind       kind;
        logic        last;
        logic [15:0] decoded_length;
    } t_result;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    localparam logic [15:0] CU_ONE_MAX  = 16'h0080;
    localparam logic [15:0] CU_TWO_MAX  = 16'h0800;
    localparam logic [15:0] CU_SURR_LO  = 16'hD800;
    localparam logic [15:0] CU_SURR_HI  = 16'hDFFF;
    localparam logic [15:0] SHOWN_MAX   = 16'hFFFF;

    // Bit 4 is set for a byte that is not a hex digit; bits 3:0 hold the digit value.
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/json_string_unescape.sv =====
// Top level of the streaming JSON string body decoder with UTF-8 output.
`default_nettype none
// Decodes the body of a JSON string, one raw byte per input transaction,
// into data, end and error results on the output channel. Each byte is
// decoded between an input register and a three-entry result buffer, so
// a byte that yields zero or one result is taken every cycle while the
// output channel is ready. A \u escape whose code unit needs two or three
// UTF-8 bytes holds the next byte while the result buffer drains, at one
// transaction per cycle when the output channel is ready. The decoded
// length saturates at 2**LENGTH_BITS - 1 internally and is shown clipped to 16 bits.
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_kind,
    output logic             o_last,
    output logic [15:0]      o_decoded_length
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    function automatic logic [LENGTH_BITS-1:0] f_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + LENGTH_BITS'(1);
    endfunction

    function automatic logic [15:0] f_shown(input logic [LENGTH_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (|w[31:16]) ? SHOWN_MAX : w[15:0];
    endfunction

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    t_mode                  r_mode, n_mode;
    logic [15:0]            r_cu, n_cu;
    logic                   r_hex_bad, n_hex_bad;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    t_result                r_q [3];
    t_result                n_q [3];
    logic [1:0]             r_cnt, n_cnt;

    t_result                w_res [3];
    logic [1:0]             w_nres;
    logic                   w_pop;
    logic                   w_proc;
    logic [4:0]             w_hex;
    logic [15:0]            w_unit;
    logic                   w_bad;
    logic [LENGTH_BITS-1:0] w_c1, w_c2, w_c3;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign w_proc  = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop));
    assign o_ready = !r_in_valid || w_proc;

    assign w_hex  = f_hex(r_in_byte);
    assign w_unit = {r_cu[11:0], w_hex[3:0] & {4{~w_hex[4]}}};
    assign w_bad  = r_hex_bad || w_hex[4];
    assign w_c1   = f_inc(r_len);
    assign w_c2   = f_inc(w_c1);
    assign w_c3   = f_inc(w_c2);

    // Next decode mode and the hex digit gathering.
    always_comb begin
        n_mode    = r_mode;
        n_cu      = r_cu;
        n_hex_bad = r_hex_bad;
        if (w_proc) begin
            unique case (r_mode)
                MODE_ESCAPE: begin
                    if (r_in_byte == CH_U) begin
                        n_mode    = MODE_HEX0;
                        n_cu      = '0;
                        n_hex_bad = 1'b0;
                    end else begin
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
                    n_mode    = t_mode'(r_mode + 3'd1);
                    n_cu      = w_unit;
                    n_hex_bad = w_bad;
                end
                MODE_HEX3: begin
                    n_mode    = MODE_NORMAL;
                    n_cu      = w_unit;
                    n_hex_bad = w_bad;
                end
                default: begin
                    n_mode = (r_in_byte == CH_BACKSLASH) ? MODE_ESCAPE : MODE_NORMAL;
                end
            endcase
        end
    end

    // Results of the byte in the input register and the length update.
    always_comb begin
        w_res[0] = '{out_byte: 8'h00, kind: KIND_DATA, last: 1'b0, decoded_length: 16'h0};
        w_res[1] = w_res[0];
        w_res[2] = w_res[0];
        w_nres   = 2'd0;
        n_len    = r_len;
        unique case (r_mode)
            MODE_ESCAPE: begin
                w_nres = 2'd1;
                n_len  = w_c1;
                w_res[0].decoded_length = f_shown(w_c1);
                case (r_in_byte)
                    CH_QUOTE, CH_BACKSLASH, CH_SLASH: w_res[0].out_byte = r_in_byte;
                    CH_B: w_res[0].out_byte = 8'h08;
                    CH_F: w_res[0].out_byte = 8'h0C;
                    CH_N: w_res[0].out_byte = 8'h0A;
                    CH_R: w_res[0].out_byte = 8'h0D;
                    CH_T: w_res[0].out_byte = 8'h09;
                    CH_U: begin
                        w_nres = 2'd0;
                        n_len  = r_len;
                    end
                    default: begin
                        w_res[0].kind           = KIND_BAD_ESCAPE;
                        w_res[0].decoded_length = 16'h0;
                        n_len                   = '0;
                    end
                endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
                w_nres = 2'd0;
            end
            MODE_HEX3: begin
                if (w_bad) begin
                    w_nres        = 2'd1;
                    w_res[0].kind = KIND_BAD_HEX;
                    n_len         = '0;
                end else if (w_unit >= CU_SURR_LO && w_unit <= CU_SURR_HI) begin
                    w_nres        = 2'd1;
                    w_res[0].kind = KIND_SURROGATE;
                    n_len         = '0;
                end else if (w_unit < CU_ONE_MAX) begin
                    w_nres                  = 2'd1;
                    n_len                   = w_c1;
                    w_res[0].out_byte       = w_unit[7:0];
                    w_res[0].decoded_length = f_shown(w_c1);
                end else if (w_unit < CU_TWO_MAX) begin
                    w_nres                  = 2'd2;
                    n_len                   = w_c2;
                    w_res[0].out_byte       = UTF8_LEAD2 | {3'b000, w_unit[10:6]};
                    w_res[0].decoded_length = f_shown(w_c1);
                    w_res[1].out_byte       = UTF8_CONT | {2'b00, w_unit[5:0]};
                    w_res[1].decoded_length = f_shown(w_c2);
                end else begin
                    w_nres                  = 2'd3;
                    n_len                   = w_c3;
                    w_res[0].out_byte       = UTF8_LEAD3 | {4'b0000, w_unit[15:12]};
                    w_res[0].decoded_length = f_shown(w_c1);
                    w_res[1].out_byte       = UTF8_CONT | {2'b00, w_unit[11:6]};
                    w_res[1].decoded_length = f_shown(w_c2);
                    w_res[2].out_byte       = UTF8_CONT | {2'b00, w_unit[5:0]};
                    w_res[2].decoded_length = f_shown(w_c3);
                end
            end
            default: begin
                if (r_in_byte == CH_BACKSLASH) begin
                    w_nres = 2'd0;
                end else if (r_in_byte == CH_QUOTE) begin
                    w_nres                  = 2'd1;
                    w_res[0].kind           = KIND_END;
                    w_res[0].decoded_length = f_shown(r_len);
                    n_len                   = '0;
                end else begin
                    w_nres                  = 2'd1;
                    n_len                   = w_c1;
                    w_res[0].out_byte       = r_in_byte;
                    w_res[0].decoded_length = f_shown(w_c1);
                end
            end
        endcase
        case (w_nres)
            2'd1:    w_res[0].last = 1'b1;
            2'd2:    w_res[1].last = 1'b1;
            2'd3:    w_res[2].last = 1'b1;
            default: ;
        endcase
        if (!w_proc) begin
            n_len = r_len;
        end
    end

    // Result buffer: head at entry zero, shifted on every output transaction.
    always_comb begin
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        n_q[2] = r_q[2];
        n_cnt  = r_cnt;
        if (w_pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_cnt  = r_cnt - 2'd1;
        end
        if (w_proc) begin
            n_q[0] = w_res[0];
            n_q[1] = w_res[1];
            n_q[2] = w_res[2];
            n_cnt  = w_nres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_NORMAL;
            r_cu       <= '0;
            r_hex_bad  <= 1'b0;
            r_len      <= '0;
            r_cnt      <= 2'd0;
        end else begin
            r_in_valid <= (i_valid && o_ready) || (r_in_valid && !w_proc);
            r_mode     <= n_mode;
            r_cu       <= n_cu;
            r_hex_bad  <= n_hex_bad;
            r_len      <= n_len;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
        r_q[2] <= n_q[2];
    end

    assign o_valid          = (r_cnt != 2'd0);
    assign o_out_byte       = r_q[0].out_byte;
    assign o_kind           = r_q[0].kind;
    assign o_last           = r_q[0].last;
    assign o_decoded_length = r_q[0].decoded_length;

`ifndef NO_ASSERTIONS
    a_last_ends_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (r_cnt == 2'd1)))
        else $error("last flag does not match the final buffered result");

    a_non_data_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_DATA) |-> (o_out_byte == 8'h00))
        else $error("non-data result carries a byte");

    a_data_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_DATA) |-> (o_decoded_length != 16'h0))
        else $error("data result with zero length");

    a_accept_loads_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_in_valid)
        else $error("accepted transaction lost from the input register");
`endif

endmodule
`default_nettype wire
